// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/qke_pkg.sv =====
// Shared types, codes and constants of the quintic kernel evaluator.
// No dependencies; imported by qke_power and quintic_kernel_eval.
`timescale 1ns / 1ps

package qke_pkg;

  // Working fraction width of the bracket powers
  localparam int GUARD     = 28;
  localparam int NORM_BITS = 32;

  // Widths of (k-s)^2, ^4, ^5 in Q.GUARD (brackets reach at most 3.0)
  localparam int U2_W = 32;
  localparam int U4_W = 35;
  localparam int U5_W = 36;

  typedef enum logic [1:0] {
    OP_VALUE = 2'd0,
    OP_DERIV = 2'd1,
    OP_OMEGA = 2'd2
  } opcode_t;

  typedef logic [NORM_BITS-1:0] norm_t;

  // Stage enables handed to a power lane
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

  // Normalisation in unsigned Q0.32: 1/120, 7/(478 pi), 3/(359 pi)
  function automatic norm_t norm_of(input logic [1:0] dims);
    norm_t n;
    case (dims)
      2'd1:    n = 32'd35791394;
      2'd2:    n = 32'd20020740;
      2'd3:    n = 32'd11424489;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/qke_power.sv =====
// One power lane: (k-s) -> (k-s)^4 and (k-s)^5 over three register stages.
// Depends on qke_pkg.
`timescale 1ns / 1ps

module qke_power
  import qke_pkg::*;
#(
  parameter int FRAC_BITS_IN = 16
) (
  input  logic                    clk,
  input  lane_en_t                en,
  input  logic [FRAC_BITS_IN+1:0] d,
  output logic [U4_W-1:0]         u4,
  output logic [U5_W-1:0]         u5
);

  localparam int DW    = FRAC_BITS_IN + 2;
  localparam int SQ_SH = 2 * (GUARD - FRAC_BITS_IN);
  localparam int SQ_W  = 2 * GUARD + 4;
  localparam int Q4_W  = 2 * U2_W;
  localparam int Q5_W  = U4_W + DW;

  logic [DW-1:0]     d2, d3;
  logic [U2_W-1:0]   u2;
  logic [U4_W-1:0]   u4_s3;
  logic [2*DW-1:0]   sq;
  logic [SQ_W-1:0]   sq_rnd;
  logic [Q4_W-1:0]   q4;
  logic [Q5_W-1:0]   q5;

  // u^2: d is Q.FRAC_BITS_IN, so u*u = d*d scaled up to Q.56, rounded to Q.28
  assign sq     = d * d;
  assign sq_rnd = {sq, {SQ_SH{1'b0}}} + (SQ_W'(1) << (GUARD - 1));

  // u^4 = (u^2)^2 rounded to Q.28
  assign q4 = u2 * u2 + (Q4_W'(1) << (GUARD - 1));

  // u^5 = u^4 * u; the low zero bits of u fold into the rounding shift
  assign q5 = u4_s3 * d3 + (Q5_W'(1) << (FRAC_BITS_IN - 1));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      u2 <= sq_rnd[GUARD+U2_W-1:GUARD];
      d2 <= d;
    end
    if (en.s3) begin
      u4_s3 <= q4[GUARD+U4_W-1:GUARD];
      d3    <= d2;
    end
    if (en.s4) begin
      u4 <= u4_s3;
      u5 <= q5[FRAC_BITS_IN+U5_W-1:FRAC_BITS_IN];
    end
  end

endmodule

// ===== hdl/quintic_kernel_eval.sv =====
// Quintic spline SPH kernel evaluator, top level: 12-stage pipeline.
// Depends on qke_pkg and qke_power.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_ready) carries opcode and distance s
//   (unsigned Q2.FRAC_BITS_IN). Output channel (out_valid/out_ready)
//   carries value, signed Q2.FRAC_BITS_OUT, saturated.
//   opcode: value W, derivative W', or smoothing-length term
//   -(d W + s W'); the unused code gives zero.
//   cfg_we/cfg_data write the dimension d (reset 3); change it only
//   while no item is in flight.
// Timing
//   out_valid rises once an accepted item reaches the last stage.
//   Throughput is one item per cycle while out_ready stays high; each
//   stage holds one item with its own valid bit.
//   Depth is set by the bracket powers (three multiply stages per lane),
//   the s*P4 product and the 32-bit normalisation, which is split in two
//   16-bit halves and summed in the next stage.
// Reset and stalls
//   rst (synchronous) clears all valid bits and sets d to 3.
//   When out_ready is low, stages fill from the output back; empty stages
//   keep accepting, so in_ready only falls once every stage holds an item.

module quintic_kernel_eval
  import qke_pkg::*;
#(
  parameter int FRAC_BITS_IN  = 16,
  parameter int FRAC_BITS_OUT = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [FRAC_BITS_IN+1:0]        distance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [FRAC_BITS_OUT+1:0] value
);

  localparam int DW     = FRAC_BITS_IN + 2;
  localparam int VW     = FRAC_BITS_OUT + 2;
  localparam int NS     = 12;
  localparam int PW     = 40;               // P5 / P4 sums, Q.28
  localparam int SW     = PW + 4;           // s*P4 rounded, Q.28
  localparam int AW     = PW + 8;           // selected accumulator
  localparam int PROD_W = PW + DW + 1;      // s*P4 exact
  localparam int HALF_W = NORM_BITS / 2;
  localparam int PL_W   = AW + HALF_W + 1;  // acc times one norm half
  localparam int SUM_W  = AW + NORM_BITS + 1;
  localparam int RS     = GUARD + NORM_BITS - FRAC_BITS_OUT;
  localparam int R_W    = SUM_W - RS;

  localparam logic [PROD_W-1:0] SP_HALF  = PROD_W'(1) << (FRAC_BITS_IN - 1);
  localparam logic [SUM_W-1:0]  FIN_HALF = SUM_W'(1) << (RS - 1);
  localparam logic signed [R_W-1:0] R_MAX = signed'(R_W'({(VW-1){1'b1}}));
  localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);
  localparam logic signed [VW-1:0]  V_MAX = signed'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [VW-1:0]  V_MIN = signed'({1'b1, {(VW-1){1'b0}}});
  localparam logic signed [7:0] C15 = 8'sd15;
  localparam logic signed [7:0] C6  = 8'sd6;
  localparam logic signed [7:0] C5  = 8'sd5;

  // Configuration
  logic [1:0] dims;

  // Pipeline control
  logic [NS:1]   vld;
  logic [NS+1:1] en;
  lane_en_t      lane_en;

  // Side-band carried along with each item
  logic [1:0]    op_p [1:7];
  logic [DW-1:0] x_p  [1:5];

  // Stage 1: brackets, stages 2-4: lanes
  logic [DW-1:0]   d_next [3];
  logic [DW-1:0]   d_s1   [3];
  logic [U4_W-1:0] u4_l   [3];
  logic [U5_W-1:0] u5_l   [3];

  // Stage 5-12 data
  logic signed [PW-1:0]     t4 [3];
  logic signed [PW-1:0]     t5 [3];
  logic signed [PW-1:0]     p5_next, p4_next;
  logic signed [PW-1:0]     p5_s5, p4_s5, p5_s6, p4_s6, p5_s7, p4_s7;
  logic signed [PROD_W-1:0] prod_next, prod_s6, sp_adj, sp_shift;
  logic signed [SW-1:0]     sp4_s7;
  logic signed [AW-1:0]     p5_ext, p4_ext, sp4_ext, acc_next, acc_s8;
  logic signed [2:0]        dim_s;
  norm_t                    norm;
  logic signed [PL_W-1:0]   pl_next, ph_next, pl_s9, ph_s9;
  logic signed [SUM_W-1:0]  sum_next, sum_s10, fin_adj, fin_shift;
  logic signed [R_W-1:0]    r_s11;
  logic signed [VW-1:0]     value_next;

  // ---------------------------------------------------------------
  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 2'd3;
    end else if (cfg_we) begin
      dims <= cfg_data;
    end
  end

  // ---------------------------------------------------------------
  // Elastic pipeline: a stage loads when it is empty or its successor
  // loads; the last stage loads when the receiver takes the item.
  always_comb begin
    en[NS+1] = out_ready;
    for (int i = NS; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NS];
  assign lane_en   = '{s2: en[2], s3: en[3], s4: en[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Side-band shift lines
  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_p[1] <= opcode;
      x_p[1]  <= distance;
    end
    for (int i = 2; i <= 7; i++) begin
      if (en[i]) begin
        op_p[i] <= op_p[i-1];
      end
    end
    for (int i = 2; i <= 5; i++) begin
      if (en[i]) begin
        x_p[i] <= x_p[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: brackets (k - s), zero once s reaches k
  for (genvar k = 0; k < 3; k++) begin : g_bracket
    localparam logic [DW-1:0] LIM = DW'(k + 1) << FRAC_BITS_IN;
    assign d_next[k] = (distance < LIM) ? LIM - distance : '0;

    always_ff @(posedge clk) begin
      if (en[1]) begin
        d_s1[k] <= d_next[k];
      end
    end

    // Stages 2-4: powers
    qke_power #(
      .FRAC_BITS_IN(FRAC_BITS_IN)
    ) u_power (
      .clk (clk),
      .en  (lane_en),
      .d   (d_s1[k]),
      .u4  (u4_l[k]),
      .u5  (u5_l[k])
    );

    assign t4[k] = signed'(PW'(u4_l[k]));
    assign t5[k] = signed'(PW'(u5_l[k]));
  end

  // Stage 5: weighted sums, weights 15, -6, 1 for k = 1, 2, 3
  assign p5_next = C15 * t5[0] - C6 * t5[1] + t5[2];
  assign p4_next = C15 * t4[0] - C6 * t4[1] + t4[2];

  // Stage 6: s * P4, exact
  assign prod_next = p4_s5 * signed'({1'b0, x_p[5]});

  // Stage 7: round s*P4 to Q.28, half away from zero.
  // (v + half - sign) >>> sh equals sign * ((|v| + half) >> sh).
  assign sp_adj   = prod_s6 + signed'(SP_HALF) - signed'(PROD_W'(prod_s6[PROD_W-1]));
  assign sp_shift = sp_adj >>> FRAC_BITS_IN;

  // Stage 8: select the quantity
  assign p5_ext  = AW'(p5_s7);
  assign p4_ext  = AW'(p4_s7);
  assign sp4_ext = AW'(sp4_s7);
  assign dim_s   = signed'({1'b0, dims});

  always_comb begin
    case (opcode_t'(op_p[7]))
      OP_VALUE: acc_next = p5_ext;
      OP_DERIV: acc_next = -(C5 * p4_ext);
      OP_OMEGA: acc_next = C5 * sp4_ext - dim_s * p5_ext;
      default:  acc_next = '0;
    endcase
  end

  // Stage 9: accumulator times the two 16-bit halves of N
  assign norm    = norm_of(dims);
  assign pl_next = acc_s8 * signed'({1'b0, norm[HALF_W-1:0]});
  assign ph_next = acc_s8 * signed'({1'b0, norm[NORM_BITS-1:HALF_W]});

  // Stage 10: recombine to Q.60
  assign sum_next = (SUM_W'(ph_s9) <<< HALF_W) + SUM_W'(pl_s9);

  // Stage 11: round to output fraction, half away from zero
  assign fin_adj   = sum_s10 + signed'(FIN_HALF) - signed'(SUM_W'(sum_s10[SUM_W-1]));
  assign fin_shift = fin_adj >>> RS;

  // Stage 12: saturate
  always_comb begin
    if (r_s11 > R_MAX) begin
      value_next = V_MAX;
    end else if (r_s11 < R_MIN) begin
      value_next = V_MIN;
    end else begin
      value_next = VW'(r_s11);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5_s5 <= p5_next;
      p4_s5 <= p4_next;
    end
    if (en[6]) begin
      prod_s6 <= prod_next;
      p5_s6   <= p5_s5;
      p4_s6   <= p4_s5;
    end
    if (en[7]) begin
      sp4_s7 <= SW'(sp_shift);
      p5_s7  <= p5_s6;
      p4_s7  <= p4_s6;
    end
    if (en[8]) begin
      acc_s8 <= acc_next;
    end
    if (en[9]) begin
      pl_s9 <= pl_next;
      ph_s9 <= ph_next;
    end
    if (en[10]) begin
      sum_s10 <= sum_next;
    end
    if (en[11]) begin
      r_s11 <= R_W'(fin_shift);
    end
    if (en[12]) begin
      value <= value_next;
    end
  end

endmodule

// ===== hdl/qke_checker.sv =====
// Port-level checker for quintic_kernel_eval, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qke_port_checker #(
  parameter int VALUE_W = 22
) (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] value
);

  // A stalled result stays offered and unchanged
  `ASSERT_ON_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_ON_CLK(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(value), "result changed")

  // Reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result offered right after reset")

  // Input can only be held off by a full pipeline, which shows a result
  `ASSERT_ON_CLK(a_no_false_stall, clk, rst, !out_valid |-> in_ready, "input stalled, output empty")

endmodule

bind quintic_kernel_eval qke_port_checker #(
  .VALUE_W(FRAC_BITS_OUT + 2)
) u_qke_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value)
);
